FILE: sv/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("assertion failed");

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Antecedent implies consequent in the next cycle.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: sv/lpfi_pkg.sv
`default_nettype none

package lpfi_pkg;

  localparam int KEY_W          = 64;
  localparam int CFG_W          = 11;
  localparam int OCC_W          = 11;
  localparam int MAX_SLOTS_DEF  = 1024;
  localparam int SLOT_COUNT_RST = 1024;
  localparam int OCC_MAX        = 2047;

  // Modulo unit: bits of the key consumed per cycle.
  localparam int MOD_BITS  = 4;
  localparam int MOD_STEPS = KEY_W / MOD_BITS;
  localparam int STEP_W    = $clog2(MOD_STEPS);

  typedef enum logic [1:0] {
    OUT_INSERTED = 2'd0,
    OUT_FOUND    = 2'd1,
    OUT_FULL     = 2'd2
  } outcome_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_MOD,
    F_PUSH
  } front_state_t;

  typedef enum logic [1:0] {
    B_CLEAR,
    B_IDLE,
    B_PROBE
  } back_state_t;

endpackage

`default_nettype wire

FILE: sv/lpfi_front.sv
`default_nettype none

module lpfi_front #(
  parameter int MAX_SLOTS = lpfi_pkg::MAX_SLOTS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_fire,
  input  logic [lpfi_pkg::KEY_W-1:0]        in_key,
  input  logic [lpfi_pkg::CFG_W-1:0]        n_eff,
  output logic                              busy,
  input  logic                              q_full,
  output logic                              q_push,
  output logic [lpfi_pkg::KEY_W-1:0]        q_key,
  output logic [((MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1)-1:0] q_home
);

  localparam int IDX_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;

  lpfi_pkg::front_state_t state, state_next;

  logic [lpfi_pkg::KEY_W-1:0]  key;
  logic [lpfi_pkg::KEY_W-1:0]  sh;
  logic [lpfi_pkg::CFG_W-1:0]  rem;
  logic [lpfi_pkg::CFG_W-1:0]  rem_next;
  logic [lpfi_pkg::STEP_W-1:0] step;
  logic                        last_step;

  assign last_step = (step == lpfi_pkg::STEP_W'(lpfi_pkg::MOD_STEPS - 1));

  // Restoring remainder, a few key bits per cycle, MSB first.
  always_comb begin
    logic [lpfi_pkg::CFG_W:0] r;
    r = {1'b0, rem};
    for (int i = 0; i < lpfi_pkg::MOD_BITS; i++) begin
      r = {r[lpfi_pkg::CFG_W-1:0], sh[lpfi_pkg::KEY_W-1-i]};
      if (r >= {1'b0, n_eff}) begin
        r = r - {1'b0, n_eff};
      end
    end
    rem_next = r[lpfi_pkg::CFG_W-1:0];
  end

  always_comb begin
    state_next = state;
    unique case (state)
      lpfi_pkg::F_IDLE: begin
        if (in_fire) state_next = lpfi_pkg::F_MOD;
      end
      lpfi_pkg::F_MOD: begin
        if (last_step) state_next = lpfi_pkg::F_PUSH;
      end
      lpfi_pkg::F_PUSH: begin
        if (!q_full) state_next = lpfi_pkg::F_IDLE;
      end
      default: state_next = lpfi_pkg::F_IDLE;
    endcase
  end

  always_comb begin
    busy   = 1'b1;
    q_push = 1'b0;
    unique case (state)
      lpfi_pkg::F_IDLE: busy   = 1'b0;
      lpfi_pkg::F_MOD:  busy   = 1'b1;
      lpfi_pkg::F_PUSH: q_push = !q_full;
      default:          busy   = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lpfi_pkg::F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == lpfi_pkg::F_IDLE && in_fire) begin
      key  <= in_key;
      sh   <= in_key;
      rem  <= '0;
      step <= '0;
    end else if (state == lpfi_pkg::F_MOD) begin
      sh   <= sh << lpfi_pkg::MOD_BITS;
      rem  <= rem_next;
      step <= step + 1'b1;
    end
  end

  assign q_key  = key;
  assign q_home = IDX_W'(rem);

endmodule

`default_nettype wire

FILE: sv/lpfi_queue.sv
`default_nettype none

`include "assert_macros.svh"

module lpfi_queue #(
  parameter int MAX_SLOTS = lpfi_pkg::MAX_SLOTS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              push,
  input  logic [lpfi_pkg::KEY_W-1:0]        push_key,
  input  logic [((MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1)-1:0] push_home,
  output logic                              full,
  input  logic                              pop,
  output logic [lpfi_pkg::KEY_W-1:0]        pop_key,
  output logic [((MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1)-1:0] pop_home,
  output logic                              empty
);

  localparam int IDX_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;

  logic [lpfi_pkg::KEY_W-1:0] key_q  [2];
  logic [IDX_W-1:0]           home_q [2];
  logic                       wr_ptr;
  logic                       rd_ptr;
  logic [1:0]                 cnt;
  logic                       do_push;
  logic                       do_pop;

  assign full    = (cnt == 2'd2);
  assign empty   = (cnt == 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      cnt    <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= !wr_ptr;
      if (do_pop)  rd_ptr <= !rd_ptr;
      cnt <= cnt + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      key_q[wr_ptr]  <= push_key;
      home_q[wr_ptr] <= push_home;
    end
  end

  assign pop_key  = key_q[rd_ptr];
  assign pop_home = home_q[rd_ptr];

  `ASSERT_ALWAYS(a_cnt_range, clk, rst, cnt <= 2'd2)

endmodule

`default_nettype wire

FILE: sv/lpfi_back.sv
`default_nettype none

`include "assert_macros.svh"

module lpfi_back #(
  parameter int MAX_SLOTS = lpfi_pkg::MAX_SLOTS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic [lpfi_pkg::CFG_W-1:0]        n_eff,
  output logic                              clearing,
  input  logic                              q_empty,
  input  logic [lpfi_pkg::KEY_W-1:0]        q_key,
  input  logic [((MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1)-1:0] q_home,
  output logic                              q_pop,
  input  logic                              pop,
  output logic                              empty,
  output logic [((MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1)-1:0] slot_index,
  output logic [1:0]                        outcome,
  output logic [lpfi_pkg::OCC_W-1:0]        occupied
);

  localparam int IDX_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;

  lpfi_pkg::back_state_t state, state_next;

  logic [lpfi_pkg::KEY_W-1:0] key_mem   [MAX_SLOTS];
  logic                       valid_mem [MAX_SLOTS];

  logic [IDX_W-1:0]           clr_addr;
  logic [IDX_W-1:0]           slot;
  logic [IDX_W-1:0]           home;
  logic [lpfi_pkg::KEY_W-1:0] key;
  logic [lpfi_pkg::OCC_W-1:0] occ;
  logic [lpfi_pkg::OCC_W-1:0] occ_next;
  logic                       occ_inc;

  logic                       out_valid;
  logic [IDX_W-1:0]           out_slot;
  lpfi_pkg::outcome_t         out_outcome;
  logic [lpfi_pkg::OCC_W-1:0] out_occ;

  logic [lpfi_pkg::KEY_W-1:0] rd_key;
  logic                       rd_valid;
  logic [IDX_W-1:0]           rd_addr;
  logic                       valid_we;
  logic [IDX_W-1:0]           valid_wa;
  logic                       valid_wd;
  logic                       key_we;

  logic [IDX_W:0]             slot_inc;
  logic [IDX_W-1:0]           next_slot;
  logic                       start;
  logic                       hit_empty;
  logic                       hit_key;
  logic                       last_probe;
  logic                       done;
  logic                       insert;
  logic                       clr_last;

  assign start      = !q_empty && (!out_valid || pop);
  assign slot_inc   = {1'b0, slot} + 1'b1;
  // Wrap at the last slot in use.
  assign next_slot  = (32'(slot_inc) >= 32'(n_eff)) ? '0 : slot_inc[IDX_W-1:0];
  assign hit_empty  = !rd_valid;
  assign hit_key    = (rd_key == key);
  assign last_probe = (next_slot == home);
  assign done       = (state == lpfi_pkg::B_PROBE) && (hit_empty || hit_key || last_probe);
  assign insert     = (state == lpfi_pkg::B_PROBE) && hit_empty;
  assign clr_last   = (clr_addr == IDX_W'(MAX_SLOTS - 1));

  assign occ_inc  = insert && (occ != lpfi_pkg::OCC_W'(lpfi_pkg::OCC_MAX));
  assign occ_next = occ_inc ? occ + 1'b1 : occ;

  always_comb begin
    state_next = state;
    unique case (state)
      lpfi_pkg::B_CLEAR: begin
        if (clr_last) state_next = lpfi_pkg::B_IDLE;
      end
      lpfi_pkg::B_IDLE: begin
        if (start) state_next = lpfi_pkg::B_PROBE;
      end
      lpfi_pkg::B_PROBE: begin
        if (done) state_next = lpfi_pkg::B_IDLE;
      end
      default: state_next = lpfi_pkg::B_CLEAR;
    endcase
  end

  always_comb begin
    clearing = 1'b0;
    q_pop    = 1'b0;
    rd_addr  = next_slot;
    valid_we = 1'b0;
    valid_wa = slot;
    valid_wd = 1'b1;
    key_we   = 1'b0;
    unique case (state)
      lpfi_pkg::B_CLEAR: begin
        clearing = 1'b1;
        valid_we = 1'b1;
        valid_wa = clr_addr;
        valid_wd = 1'b0;
      end
      lpfi_pkg::B_IDLE: begin
        q_pop   = start;
        rd_addr = q_home;
      end
      lpfi_pkg::B_PROBE: begin
        // Issue the next slot speculatively; drop the data if this probe ends.
        valid_we = insert;
        key_we   = insert;
      end
      default: clearing = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (valid_we) valid_mem[valid_wa] <= valid_wd;
    rd_valid <= valid_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (key_we) key_mem[slot] <= key;
    rd_key <= key_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= lpfi_pkg::B_CLEAR;
      clr_addr  <= '0;
      occ       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == lpfi_pkg::B_CLEAR) clr_addr <= clr_addr + 1'b1;
      occ <= occ_next;
      if (done) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == lpfi_pkg::B_IDLE && start) begin
      slot <= q_home;
      home <= q_home;
      key  <= q_key;
    end else if (state == lpfi_pkg::B_PROBE && !done) begin
      slot <= next_slot;
    end
    if (done) begin
      out_occ <= occ_next;
      if (hit_empty) begin
        out_slot    <= slot;
        out_outcome <= lpfi_pkg::OUT_INSERTED;
      end else if (hit_key) begin
        out_slot    <= slot;
        out_outcome <= lpfi_pkg::OUT_FOUND;
      end else begin
        out_slot    <= '0;
        out_outcome <= lpfi_pkg::OUT_FULL;
      end
    end
  end

  assign empty      = !out_valid;
  assign slot_index = out_slot;
  assign outcome    = out_outcome;
  assign occupied   = out_occ;

  `ASSERT_IMPLIES(a_out_free_on_done, clk, rst, done, !out_valid)
  `ASSERT_NEXT(a_occ_step, clk, rst, occ_inc, occ == $past(occ) + 1'b1)
  `ASSERT_IMPLIES(a_full_slot_zero, clk, rst, out_valid && out_outcome == lpfi_pkg::OUT_FULL, out_slot == '0)

endmodule

`default_nettype wire

FILE: sv/linear_probe_find_or_insert_core.sv
`default_nettype none

// Find-or-insert of 64-bit keys in an open-addressing hash table with linear
// probing. The front computes the home slot (key modulo the slot count) in a
// remainder unit that takes 4 key bits per cycle; the back then probes the
// slot memories at one slot per cycle. A two-word queue between them lets the
// next key's remainder overlap the current probe walk; the front takes a new
// key only after it has handed the last one to the queue. After reset the
// valid store is swept clear slot by slot, and full stays high during the
// sweep. Write slot_count only while the block is idle.

module linear_probe_find_or_insert_core #(
  parameter int MAX_SLOTS = lpfi_pkg::MAX_SLOTS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              slot_count_we,
  input  logic [lpfi_pkg::CFG_W-1:0]        slot_count,
  input  logic                              push,
  output logic                              full,
  input  logic [lpfi_pkg::KEY_W-1:0]        key_hash,
  input  logic                              pop,
  output logic                              empty,
  output logic [((MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1)-1:0] slot_index,
  output logic [1:0]                        outcome,
  output logic [lpfi_pkg::OCC_W-1:0]        occupied
);

  localparam int IDX_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;

  logic [lpfi_pkg::CFG_W-1:0] cfg_slots;
  logic [lpfi_pkg::CFG_W-1:0] n_eff;
  logic                       front_busy;
  logic                       clearing;
  logic                       in_fire;
  logic                       q_push;
  logic                       q_full;
  logic                       q_pop;
  logic                       q_empty;
  logic [lpfi_pkg::KEY_W-1:0] f_key;
  logic [IDX_W-1:0]           f_home;
  logic [lpfi_pkg::KEY_W-1:0] b_key;
  logic [IDX_W-1:0]           b_home;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_slots <= lpfi_pkg::CFG_W'(lpfi_pkg::SLOT_COUNT_RST);
    end else if (slot_count_we) begin
      cfg_slots <= slot_count;
    end
  end

  // Zero means one slot; clamp to the table size.
  always_comb begin
    if (cfg_slots == '0) begin
      n_eff = lpfi_pkg::CFG_W'(1);
    end else if (32'(cfg_slots) > 32'(MAX_SLOTS)) begin
      n_eff = lpfi_pkg::CFG_W'(MAX_SLOTS);
    end else begin
      n_eff = cfg_slots;
    end
  end

  assign full    = front_busy || clearing;
  assign in_fire = push && !full;

  lpfi_front #(
    .MAX_SLOTS (MAX_SLOTS)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .in_fire (in_fire),
    .in_key  (key_hash),
    .n_eff   (n_eff),
    .busy    (front_busy),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_key   (f_key),
    .q_home  (f_home)
  );

  lpfi_queue #(
    .MAX_SLOTS (MAX_SLOTS)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_key  (f_key),
    .push_home (f_home),
    .full      (q_full),
    .pop       (q_pop),
    .pop_key   (b_key),
    .pop_home  (b_home),
    .empty     (q_empty)
  );

  lpfi_back #(
    .MAX_SLOTS (MAX_SLOTS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .n_eff      (n_eff),
    .clearing   (clearing),
    .q_empty    (q_empty),
    .q_key      (b_key),
    .q_home     (b_home),
    .q_pop      (q_pop),
    .pop        (pop),
    .empty      (empty),
    .slot_index (slot_index),
    .outcome    (outcome),
    .occupied   (occupied)
  );

endmodule

`default_nettype wire
